// ----- rtl/core/tked_pkg.sv -----
package tked_pkg;

   // Byte values used by the escape forms.
   localparam logic [7:0] ESC_BYTE   = 8'h1b;
   localparam logic [7:0] CH_LBRACK  = 8'h5b;
   localparam logic [7:0] CH_TILDE   = 8'h7e;
   localparam logic [7:0] CH_UPPER_O = 8'h4f;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_B = 8'h42;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_UPPER_D = 8'h44;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_UPPER_H = 8'h48;
   localparam logic [7:0] CH_UPPER_P = 8'h50;
   localparam logic [7:0] CH_UPPER_S = 8'h53;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_1 = 8'h31;
   localparam logic [7:0] CH_DIGIT_2 = 8'h32;
   localparam logic [7:0] CH_DIGIT_3 = 8'h33;
   localparam logic [7:0] CH_DIGIT_4 = 8'h34;
   localparam logic [7:0] CH_DIGIT_5 = 8'h35;
   localparam logic [7:0] CH_DIGIT_7 = 8'h37;
   localparam logic [7:0] CH_DIGIT_8 = 8'h38;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7e;

   // Event kinds.
   localparam logic [1:0] KIND_PLAIN   = 2'd0;
   localparam logic [1:0] KIND_ESCAPE  = 2'd1;
   localparam logic [1:0] KIND_ALT     = 2'd2;
   localparam logic [1:0] KIND_SPECIAL = 2'd3;

   // Special key indexes.
   localparam logic [7:0] KEY_UP     = 8'd0;
   localparam logic [7:0] KEY_DOWN   = 8'd1;
   localparam logic [7:0] KEY_RIGHT  = 8'd2;
   localparam logic [7:0] KEY_LEFT   = 8'd3;
   localparam logic [7:0] KEY_HOME   = 8'd4;
   localparam logic [7:0] KEY_END    = 8'd5;
   localparam logic [7:0] KEY_INSERT = 8'd6;
   localparam logic [7:0] KEY_DELETE = 8'd7;
   localparam logic [7:0] KEY_PGUP   = 8'd8;
   localparam logic [7:0] KEY_PGDOWN = 8'd9;
   localparam logic [7:0] KEY_F0     = 8'd10;

   localparam int WIN_MAX = 5;
   localparam logic [2:0] WIN_FULL = 3'd5;

   // One decode job handed from the front to the back.
   typedef struct packed {
      logic [4:0][7:0] win;
      logic [2:0]      n;
      logic            last;
      logic            report;
   } job_type;

   // Completion report of a job whose leftover bytes the front must hold.
   typedef struct packed {
      logic            valid;
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
   } done_type;

   // Result of decoding one escape window.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code;
      logic [2:0] len;
   } dec_type;

   // ESC [ d ~ for d from '1' to '8'.
   function automatic logic [7:0] tilde_one(input logic [2:0] idx);
      logic [7:0] k;
      unique case (idx)
         3'd0: k = KEY_HOME;
         3'd1: k = KEY_INSERT;
         3'd2: k = KEY_DELETE;
         3'd3: k = KEY_END;
         3'd4: k = KEY_PGUP;
         3'd5: k = KEY_PGDOWN;
         3'd6: k = KEY_HOME;
         default: k = KEY_END;
      endcase
      return k;
   endfunction

   // Decodes a window that starts with ESC; s is the number of bytes present.
   function automatic dec_type decode_window(input logic [4:0][7:0] v, input logic [2:0] s);
      dec_type d;
      logic    hit;
      logic [7:0] dd;
      d.kind = KIND_ESCAPE;
      d.code = ESC_BYTE;
      d.len  = 3'd1;
      hit    = 1'b0;
      dd     = 8'd0;
      if (s >= 3'd3) begin
         if (v[1] == CH_DIGIT_1 || v[1] == CH_UPPER_O) begin
            if (v[2] >= CH_UPPER_P && v[2] <= CH_UPPER_S) begin
               hit    = 1'b1;
               d.kind = KIND_SPECIAL;
               d.code = KEY_F0 + 8'd1 + (v[2] - CH_UPPER_P);
               d.len  = 3'd3;
            end
         end else if (v[1] == CH_LBRACK) begin
            if (s >= 3'd4 && v[3] == CH_TILDE && v[2] >= CH_DIGIT_1 && v[2] <= CH_DIGIT_8) begin
               hit    = 1'b1;
               d.kind = KIND_SPECIAL;
               d.code = tilde_one(3'(v[2] - CH_DIGIT_1));
               d.len  = 3'd4;
            end
            // Two-digit tilde form gives the function keys.
            if (!hit && s >= 3'd5 && v[4] == CH_TILDE) begin
               if (v[2] == CH_DIGIT_1) begin
                  if (v[3] >= CH_DIGIT_0 && v[3] <= CH_DIGIT_5) begin
                     hit = 1'b1;
                     dd  = KEY_F0 + (v[3] - CH_DIGIT_0);
                  end else if (v[3] >= CH_DIGIT_7 && v[3] <= CH_DIGIT_9) begin
                     hit = 1'b1;
                     dd  = KEY_F0 + 8'd6 + (v[3] - CH_DIGIT_7);
                  end
               end else if (v[2] == CH_DIGIT_2) begin
                  hit = 1'b1;
                  unique case (v[3])
                     CH_DIGIT_0: dd = KEY_F0 + 8'd9;
                     CH_DIGIT_1: dd = KEY_F0 + 8'd10;
                     CH_DIGIT_3: dd = KEY_F0 + 8'd11;
                     CH_DIGIT_4: dd = KEY_F0 + 8'd12;
                     default:    hit = 1'b0;
                  endcase
               end
               if (hit) begin
                  d.kind = KIND_SPECIAL;
                  d.code = dd;
                  d.len  = 3'd5;
               end
            end
            // Letter forms.
            if (!hit) begin
               hit = 1'b1;
               unique case (v[2])
                  CH_UPPER_A: d.code = KEY_UP;
                  CH_UPPER_B: d.code = KEY_DOWN;
                  CH_UPPER_C: d.code = KEY_RIGHT;
                  CH_UPPER_D: d.code = KEY_LEFT;
                  CH_UPPER_F: d.code = KEY_END;
                  CH_UPPER_H: d.code = KEY_HOME;
                  default:    hit = 1'b0;
               endcase
               if (hit) begin
                  d.kind = KIND_SPECIAL;
                  d.len  = 3'd3;
               end
            end
         end
      end
      // No match: alt plus a printable second byte, else a lone escape.
      if (!hit && s >= 3'd2 && v[1] >= CH_PRINT_LO && v[1] <= CH_PRINT_HI) begin
         d.kind = KIND_ALT;
         d.code = v[1];
         d.len  = 3'd2;
      end
      return d;
   endfunction

endpackage

// ----- rtl/core/terminal_key_escape_decoder.sv -----
// Each accepted window is pushed as a job into the queue; the back end loads it and registers
// its events on rsp, each a plain byte or a decoded window, while the front takes new bytes.
// A full window that is not at the buffer end stalls req until the back end finishes it.
// Reset is synchronous and active high; it empties the queue, the held window and rsp.
module terminal_key_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // buffer_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // key_code
   output logic [1:0] rsp_tuser,   // key_kind
   output logic       rsp_tlast    // run_last
);

   logic               push_valid;
   logic               push_ready;
   tked_pkg::job_type  push_job;
   logic               job_valid;
   logic               job_ready;
   tked_pkg::job_type  job;
   tked_pkg::done_type done;

   tked_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .done       (done)
   );

   tked_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_job    (push_job),
      .out_valid (job_valid),
      .out_ready (job_ready),
      .out_job   (job)
   );

   tked_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .done       (done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/tked_front.sv -----
module tked_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // in_byte
   input  logic                req_tlast,   // buffer_end
   output logic                push_valid,
   output tked_pkg::job_type   push_job,
   input  logic                push_ready,
   input  tked_pkg::done_type  done
);

   logic [3:0][7:0] pend_bytes_ff, pend_bytes_in;
   logic [2:0]      pend_count_ff, pend_count_in;
   logic            wait_ff, wait_in;
   logic            accept;
   logic            hold;
   logic [2:0]      n;

   // Accept only while no held window waits on the back end and the queue has room.
   assign req_tready = !wait_ff && push_ready;
   assign accept     = req_tvalid && req_tready;
   assign n          = pend_count_ff + 3'd1;

   // A window keeps collecting until it is full or the buffer ends; a plain byte with nothing held goes alone.
   assign hold = !((pend_count_ff == 3'd0 && req_tdata != tked_pkg::ESC_BYTE) ||
                   n == tked_pkg::WIN_FULL || req_tlast);

   // Build the job window from the held bytes plus the new item.
   always_comb begin
      for (int i = 0; i < tked_pkg::WIN_MAX; i++) begin
         if (3'(i) < pend_count_ff) begin
            push_job.win[i] = pend_bytes_ff[2'(i)];
         end else if (3'(i) == pend_count_ff) begin
            push_job.win[i] = req_tdata;
         end else begin
            push_job.win[i] = 8'd0;
         end
      end
      push_job.n      = n;
      push_job.last   = req_tlast;
      push_job.report = !req_tlast && n == tked_pkg::WIN_FULL;
   end

   assign push_valid = accept && !hold;

   // Pending window and wait flag.
   always_comb begin
      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      wait_in       = wait_ff;
      if (accept) begin
         if (hold) begin
            pend_bytes_in[pend_count_ff[1:0]] = req_tdata;
            pend_count_in = n;
         end else begin
            pend_count_in = 3'd0;
            wait_in       = push_job.report;
         end
      end else if (wait_ff && done.valid) begin
         pend_bytes_in = done.bytes;
         pend_count_in = done.count;
         wait_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff <= 3'd0;
         wait_ff       <= 1'b0;
      end else begin
         pend_count_ff <= pend_count_in;
         wait_ff       <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_bytes_ff <= pend_bytes_in;
   end

endmodule

// ----- rtl/core/tked_queue.sv -----
module tked_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tked_pkg::job_type  in_job,
   output logic               out_valid,
   input  logic               out_ready,
   output tked_pkg::job_type  out_job
);

   tked_pkg::job_type head_ff, head_in, tail_ff, tail_in;
   logic              head_valid_ff, head_valid_in;
   logic              tail_valid_ff, tail_valid_in;
   logic              push;
   logic              pop;

   assign in_ready  = !tail_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_job   = head_ff;
   assign push      = in_valid && !tail_valid_ff;
   assign pop       = out_ready && head_valid_ff;

   // Two-entry shift queue: the head slot is always the oldest item.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (pop) begin
         if (tail_valid_ff) begin
            head_in = tail_ff;
            if (push) begin
               tail_in = in_job;
            end else begin
               tail_valid_in = 1'b0;
            end
         end else if (push) begin
            head_in = in_job;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = in_job;
            head_valid_in = 1'b1;
         end else begin
            tail_in       = in_job;
            tail_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ----- rtl/core/tked_back.sv -----
module tked_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  tked_pkg::job_type  job,
   output tked_pkg::done_type done,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // key_code
   output logic [1:0]         rsp_tuser,   // key_kind
   output logic               rsp_tlast    // run_last
);

   tked_pkg::job_type cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic [2:0]        pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_code_ff, rsp_code_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [4:0][7:0]   v;
   logic [2:0]        s;
   tked_pkg::dec_type d;
   logic [1:0]        ev_kind;
   logic [7:0]        ev_code;
   logic [2:0]        ev_len;
   logic [2:0]        new_pos;
   logic [7:0]        next_byte;
   logic              rem_hold;
   logic              ev_last;
   logic              step;
   logic [3:0]        idx;
   logic [3:0]        done_idx;

   assign job_ready = !busy_ff;
   assign step      = busy_ff && (!rsp_valid_ff || rsp_tready);

   // Window seen from the current position.
   always_comb begin
      for (int i = 0; i < tked_pkg::WIN_MAX; i++) begin
         idx = {1'b0, pos_ff} + 4'(i);
         if (idx < 4'(tked_pkg::WIN_MAX)) begin
            v[i] = cur_ff.win[idx[2:0]];
         end else begin
            v[i] = 8'd0;
         end
      end
      s = cur_ff.n - pos_ff;
      d = tked_pkg::decode_window(v, s);
   end

   // One event per step: a plain byte or a decoded escape form.
   always_comb begin
      if (v[0] != tked_pkg::ESC_BYTE) begin
         ev_kind = tked_pkg::KIND_PLAIN;
         ev_code = v[0];
         ev_len  = 3'd1;
      end else begin
         ev_kind = d.kind;
         ev_code = d.code;
         ev_len  = d.len;
      end
      new_pos = pos_ff + ev_len;
      if (new_pos < 3'(tked_pkg::WIN_MAX)) begin
         next_byte = cur_ff.win[new_pos];
      end else begin
         next_byte = 8'd0;
      end
      // A later ESC is kept for the next window when the buffer goes on.
      rem_hold = new_pos < cur_ff.n && next_byte == tked_pkg::ESC_BYTE && !cur_ff.last;
      ev_last  = new_pos >= cur_ff.n || rem_hold;
   end

   // Leftover bytes go back to the front when a full-window job that is not at the buffer end ends.
   always_comb begin
      done.valid = step && ev_last && cur_ff.report;
      done.count = rem_hold ? (cur_ff.n - new_pos) : 3'd0;
      for (int j = 0; j < 4; j++) begin
         done_idx = {1'b0, new_pos} + 4'(j);
         if (done_idx < 4'(tked_pkg::WIN_MAX)) begin
            done.bytes[j] = cur_ff.win[done_idx[2:0]];
         end else begin
            done.bytes[j] = 8'd0;
         end
      end
   end

   // Job sequencing and output register.
   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (!busy_ff) begin
         if (job_valid) begin
            cur_in  = job;
            busy_in = 1'b1;
            pos_in  = 3'd0;
         end
      end else if (step) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = ev_code;
         rsp_kind_in  = ev_kind;
         rsp_last_in  = ev_last;
         pos_in       = new_pos;
         busy_in      = !ev_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      rsp_code_ff <= rsp_code_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // The position never runs past the bytes of the job.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff < cur_ff.n)
      else $error("decode position past end of job");

   // Leftover bytes are only reported for a full window.
   a_done_report: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> (cur_ff.report && done.count <= 3'd4))
      else $error("bad completion report");

   // An event that is not the last keeps the job running.
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (step && !ev_last) |=> (busy_ff && rsp_tvalid && !rsp_tlast))
      else $error("job ended without a last event");

   // The last event of a job frees the back end.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (step && ev_last) |=> !busy_ff)
      else $error("job still busy after its last event");
`endif

endmodule
